@@ hw/rtl/wbxml_token_parser_assert.svh @@
// ---------------------------------------------------------------------------
// WBXML token parser assertion macros
// Shared concurrent assertion forms; the using module provides clk_i, rst_ni.
// ---------------------------------------------------------------------------
`ifndef WBXML_TOKEN_PARSER_ASSERT_SVH
`define WBXML_TOKEN_PARSER_ASSERT_SVH

// same-cycle implication
`define WTP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wtp_pkg.sv @@
// ---------------------------------------------------------------------------
// WBXML token parser package
// Types, token codes and sizing shared by the parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int StackCntW   = $clog2(STACK_DEPTH + 1);
  localparam int StackIdxW   = $clog2(STACK_DEPTH);

  localparam logic [7:0] TOK_END    = 8'h01;
  localparam logic [7:0] TOK_STR_I  = 8'h03;
  localparam logic [7:0] TOK_OPAQUE = 8'hC3;

  typedef enum logic [3:0] {
    PH_VERSION,
    PH_PUBID,
    PH_PUBIDX,
    PH_CHARSET,
    PH_STRTBL_LEN,
    PH_STRTBL_SKIP,
    PH_BODY,
    PH_STR,
    PH_OPQ_LEN,
    PH_OPQ_DATA
  } phase_e;

  typedef enum logic [2:0] {
    EV_START,
    EV_OPEN,
    EV_EMPTY,
    EV_CLOSE,
    EV_TEXT,
    EV_TEXT_END,
    EV_END_DOC,
    EV_ERROR
  } event_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EARLY_END,
    ST_EMPTY_CLOSE,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    event_kind_e kind;
    logic [5:0]  tag;
    logic [7:0]  text_byte;
    logic [7:0]  version;
    logic [31:0] public_id;
    logic        public_id_is_index;
    logic [31:0] charset;
    status_e     status;
    logic [5:0]  nesting_depth;
  } event_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [5:0] push_tag;
  } stack_cmd_t;

  typedef struct packed {
    logic [StackCntW-1:0] count;
    logic [5:0]           top_tag;
  } stack_stat_t;

endpackage

@@ hw/rtl/wtp_stack.sv @@
// ---------------------------------------------------------------------------
// WBXML tag stack
// Open-element tag stack with element count; top entry read combinationally.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wbxml_token_parser_assert.svh"

module wtp_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wtp_pkg::stack_cmd_t cmd_i,
  output wtp_pkg::stack_stat_t stat_o
);

  logic [5:0]                    entries_q [wtp_pkg::STACK_DEPTH];
  logic [wtp_pkg::StackCntW-1:0] count_q, count_d;
  logic [wtp_pkg::StackCntW-1:0] count_m1;

  assign count_m1 = count_q - wtp_pkg::StackCntW'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + wtp_pkg::StackCntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clear) begin
      entries_q[count_q[wtp_pkg::StackIdxW-1:0]] <= cmd_i.push_tag;
    end
  end

  assign stat_o.count   = count_q;
  assign stat_o.top_tag = entries_q[count_m1[wtp_pkg::StackIdxW-1:0]];

  `WTP_ASSERT_IMPLY(a_count_bound, 1'b1,
                    count_q <= wtp_pkg::StackCntW'(wtp_pkg::STACK_DEPTH), "stack count overrun")
  `WTP_ASSERT_NEXT(a_clear_empties, cmd_i.clear, count_q == '0, "stack not cleared")
  `WTP_ASSERT_IMPLY(a_no_push_pop, 1'b1, !(cmd_i.push && cmd_i.pop), "push and pop together")

endmodule

@@ hw/rtl/wtp_parser.sv @@
// ---------------------------------------------------------------------------
// WBXML parse engine
// Header and body phases; one byte per accept_i cycle into at most one event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 op_i,
  input  logic [7:0]           data_byte_i,
  input  wtp_pkg::stack_stat_t stk_i,
  output wtp_pkg::stack_cmd_t  stk_cmd_o,
  output logic                 res_valid_o,
  output wtp_pkg::event_t      res_o
);

  wtp_pkg::phase_e phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  ver_q, ver_d;
  logic [31:0] pid_q, pid_d;
  logic        pidx_q, pidx_d;
  logic [31:0] cset_q, cset_d;
  logic [31:0] rem_q, rem_d;
  logic        err_q, err_d;

  logic [31:0] mb_val;
  logic [31:0] rem_dec;
  logic [5:0]  depth_now;
  logic [5:0]  depth_up;
  logic [5:0]  depth_dn;

  assign mb_val    = {acc_q[24:0], data_byte_i[6:0]};
  assign rem_dec   = rem_q - 32'd1;
  assign depth_now = 6'(stk_i.count);
  assign depth_up  = 6'(stk_i.count + wtp_pkg::StackCntW'(1));
  assign depth_dn  = 6'(stk_i.count - wtp_pkg::StackCntW'(1));

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    ver_d       = ver_q;
    pid_d       = pid_q;
    pidx_d      = pidx_q;
    cset_d      = cset_q;
    rem_d       = rem_q;
    err_d       = err_q;
    stk_cmd_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = wtp_pkg::EV_START;
    res_o.status = wtp_pkg::ST_OK;

    if (accept_i) begin
      if (op_i) begin
        res_valid_o = 1'b1;
        res_o.kind  = wtp_pkg::EV_END_DOC;
        if (!err_q && (phase_q != wtp_pkg::PH_BODY || stk_i.count != '0)) begin
          res_o.kind   = wtp_pkg::EV_ERROR;
          res_o.status = wtp_pkg::ST_EARLY_END;
        end
        phase_d         = wtp_pkg::PH_VERSION;
        acc_d           = '0;
        ver_d           = '0;
        pid_d           = '0;
        pidx_d          = 1'b0;
        cset_d          = '0;
        rem_d           = '0;
        err_d           = 1'b0;
        stk_cmd_o.clear = 1'b1;
      end else if (!err_q) begin
        res_o.nesting_depth = depth_now;
        unique case (phase_q)
          wtp_pkg::PH_VERSION: begin
            ver_d   = data_byte_i;
            acc_d   = '0;
            phase_d = wtp_pkg::PH_PUBID;
          end
          wtp_pkg::PH_PUBID, wtp_pkg::PH_PUBIDX, wtp_pkg::PH_CHARSET,
          wtp_pkg::PH_STRTBL_LEN, wtp_pkg::PH_OPQ_LEN: begin
            if (data_byte_i[7]) begin
              acc_d = mb_val;
            end else begin
              acc_d = '0;
              unique case (phase_q)
                wtp_pkg::PH_PUBID: begin
                  if (mb_val == '0) begin
                    phase_d = wtp_pkg::PH_PUBIDX;
                  end else begin
                    pid_d   = mb_val;
                    pidx_d  = 1'b0;
                    phase_d = wtp_pkg::PH_CHARSET;
                  end
                end
                wtp_pkg::PH_PUBIDX: begin
                  pid_d   = mb_val;
                  pidx_d  = 1'b1;
                  phase_d = wtp_pkg::PH_CHARSET;
                end
                wtp_pkg::PH_CHARSET: begin
                  cset_d  = mb_val;
                  phase_d = wtp_pkg::PH_STRTBL_LEN;
                end
                wtp_pkg::PH_STRTBL_LEN: begin
                  if (mb_val == '0) begin
                    phase_d     = wtp_pkg::PH_BODY;
                    res_valid_o = 1'b1;
                    res_o.kind  = wtp_pkg::EV_START;
                  end else begin
                    rem_d   = mb_val;
                    phase_d = wtp_pkg::PH_STRTBL_SKIP;
                  end
                end
                default: begin
                  if (mb_val == '0) begin
                    phase_d = wtp_pkg::PH_BODY;
                  end else begin
                    rem_d   = mb_val;
                    phase_d = wtp_pkg::PH_OPQ_DATA;
                  end
                end
              endcase
            end
          end
          wtp_pkg::PH_STRTBL_SKIP: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d     = wtp_pkg::PH_BODY;
              res_valid_o = 1'b1;
              res_o.kind  = wtp_pkg::EV_START;
            end
          end
          wtp_pkg::PH_STR: begin
            res_valid_o = 1'b1;
            if (data_byte_i == '0) begin
              phase_d    = wtp_pkg::PH_BODY;
              res_o.kind = wtp_pkg::EV_TEXT_END;
            end else begin
              res_o.kind      = wtp_pkg::EV_TEXT;
              res_o.text_byte = data_byte_i;
            end
          end
          wtp_pkg::PH_OPQ_DATA: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = wtp_pkg::PH_BODY;
            end
            res_valid_o     = 1'b1;
            res_o.kind      = wtp_pkg::EV_TEXT;
            res_o.text_byte = data_byte_i;
          end
          wtp_pkg::PH_BODY: begin
            if (data_byte_i == wtp_pkg::TOK_END) begin
              res_valid_o = 1'b1;
              if (stk_i.count == '0) begin
                err_d        = 1'b1;
                res_o.kind   = wtp_pkg::EV_ERROR;
                res_o.status = wtp_pkg::ST_EMPTY_CLOSE;
              end else begin
                stk_cmd_o.pop       = 1'b1;
                res_o.kind          = wtp_pkg::EV_CLOSE;
                res_o.tag           = stk_i.top_tag;
                res_o.nesting_depth = depth_dn;
              end
            end else if (data_byte_i == wtp_pkg::TOK_STR_I) begin
              phase_d = wtp_pkg::PH_STR;
            end else if (data_byte_i == wtp_pkg::TOK_OPAQUE) begin
              acc_d   = '0;
              phase_d = wtp_pkg::PH_OPQ_LEN;
            end else if (data_byte_i[6]) begin
              res_valid_o = 1'b1;
              if (stk_i.count >= wtp_pkg::StackCntW'(wtp_pkg::STACK_DEPTH)) begin
                err_d        = 1'b1;
                res_o.kind   = wtp_pkg::EV_ERROR;
                res_o.status = wtp_pkg::ST_OVERFLOW;
              end else begin
                stk_cmd_o.push      = 1'b1;
                stk_cmd_o.push_tag  = data_byte_i[5:0];
                res_o.kind          = wtp_pkg::EV_OPEN;
                res_o.tag           = data_byte_i[5:0];
                res_o.nesting_depth = depth_up;
              end
            end else begin
              res_valid_o = 1'b1;
              res_o.kind  = wtp_pkg::EV_EMPTY;
              res_o.tag   = data_byte_i[5:0];
            end
          end
          default: begin
            phase_d = wtp_pkg::PH_VERSION;
          end
        endcase
        if (res_o.kind == wtp_pkg::EV_START) begin
          res_o.version            = ver_q;
          res_o.public_id          = pid_q;
          res_o.public_id_is_index = pidx_q;
          res_o.charset            = cset_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wtp_pkg::PH_VERSION;
      acc_q   <= '0;
      ver_q   <= '0;
      pid_q   <= '0;
      pidx_q  <= 1'b0;
      cset_q  <= '0;
      rem_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ver_q   <= ver_d;
      pid_q   <= pid_d;
      pidx_q  <= pidx_d;
      cset_q  <= cset_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ hw/rtl/wtp_out_buf.sv @@
// ---------------------------------------------------------------------------
// WBXML event output buffer
// Result register plus one skid entry between parse engine and receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wbxml_token_parser_assert.svh"

module wtp_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  input  wtp_pkg::event_t res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output wtp_pkg::event_t out_o
);

  logic            out_v_q, out_v_d;
  logic            skid_v_q, skid_v_d;
  wtp_pkg::event_t out_q, out_d;
  wtp_pkg::event_t skid_q, skid_d;
  logic            pop;

  assign pop = out_v_q && !out_stall_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_v_q || pop) begin
        out_d   = res_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  `WTP_ASSERT_IMPLY(a_skid_behind_out, skid_v_q, out_v_q, "skid holds data with output empty")
  `WTP_ASSERT_NEXT(a_result_kept, out_v_q && out_stall_i, out_v_q, "stalled result dropped")

endmodule

@@ hw/rtl/wbxml_token_parser.sv @@
// ---------------------------------------------------------------------------
// WBXML token parser
// Streams a WBXML document byte by byte and emits header, element, text, end and error events.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): op_i = 0 carries one document
//   byte in data_byte_i, op_i = 1 marks end of document. A transfer takes
//   place at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i): zero or one event per input
//   transfer, in input order, with header values on start_doc.
//   Each event is registered in the output register, or in the skid entry
//   when the receiver stalls. Throughput: one byte per cycle unless stalled;
//   each byte needs one phase update and at most one tag stack access.
//   When the receiver stalls, the output register holds the event and one
//   more event goes into a skid entry; in_stall_o rises only while that
//   skid entry is occupied.
//   Reset: parser returns to the version phase, tag stack empty, no error,
//   no pending events. End of document resets phase, tag stack and error alike.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbxml_token_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [5:0]  tag_o,
  output logic [7:0]  text_byte_o,
  output logic [7:0]  version_o,
  output logic [31:0] public_id_o,
  output logic        public_id_is_index_o,
  output logic [31:0] charset_o,
  output logic [1:0]  status_o,
  output logic [5:0]  nesting_depth_o
);

  logic                 accept;
  logic                 full;
  logic                 res_valid;
  wtp_pkg::event_t      res;
  wtp_pkg::event_t      out_ev;
  wtp_pkg::stack_cmd_t  stk_cmd;
  wtp_pkg::stack_stat_t stk_stat;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  wtp_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .stat_o (stk_stat)
  );

  wtp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .stk_i       (stk_stat),
    .stk_cmd_o   (stk_cmd),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wtp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_ev)
  );

  assign event_kind_o         = out_ev.kind;
  assign tag_o                = out_ev.tag;
  assign text_byte_o          = out_ev.text_byte;
  assign version_o            = out_ev.version;
  assign public_id_o          = out_ev.public_id;
  assign public_id_is_index_o = out_ev.public_id_is_index;
  assign charset_o            = out_ev.charset;
  assign status_o             = out_ev.status;
  assign nesting_depth_o      = out_ev.nesting_depth;

endmodule

@@ tb/wbxml_token_parser_tb.sv @@
// ---------------------------------------------------------------------------
// WBXML token parser testbench
// Sends directed and random WBXML documents byte by byte, predicts every
// parser event in a local model and compares each output transfer field by
// field, with random sender gaps, receiver stalls and one long receiver hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbxml_token_parser_tb;

  localparam int ITEM_TARGET    = 1900;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [5:0]  tag_o;
  logic [7:0]  text_byte_o;
  logic [7:0]  version_o;
  logic [31:0] public_id_o;
  logic        public_id_is_index_o;
  logic [31:0] charset_o;
  logic [1:0]  status_o;
  logic [5:0]  nesting_depth_o;

  wbxml_token_parser DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .event_kind_o        (event_kind_o),
    .tag_o               (tag_o),
    .text_byte_o         (text_byte_o),
    .version_o           (version_o),
    .public_id_o         (public_id_o),
    .public_id_is_index_o(public_id_is_index_o),
    .charset_o           (charset_o),
    .status_o            (status_o),
    .nesting_depth_o     (nesting_depth_o)
  );

  always #2 clk_i = ~clk_i;

  // parser model state
  wtp_pkg::phase_e ph;
  logic [31:0] mb_acc;
  logic [7:0]  hdr_version;
  logic [31:0] hdr_pubid;
  logic        hdr_pubid_idx;
  logic [31:0] hdr_charset;
  logic [31:0] run_left;
  logic [5:0]  tag_stk [wtp_pkg::STACK_DEPTH];
  int          open_cnt;
  bit          sticky_err;

  wtp_pkg::event_t pending_events [$];
  int     err_cnt = 0;
  int     sent_cnt = 0;
  int     evt_cnt = 0;
  int     stuck_cycles = 0;
  logic   idle_on = 1'b1;
  logic   hold_req = 1'b0;

  function automatic void clear_parser_model();
    ph            = wtp_pkg::PH_VERSION;
    mb_acc        = '0;
    hdr_version   = '0;
    hdr_pubid     = '0;
    hdr_pubid_idx = 1'b0;
    hdr_charset   = '0;
    run_left      = '0;
    open_cnt      = 0;
    sticky_err    = 1'b0;
  endfunction

  function automatic wtp_pkg::event_t make_event(input wtp_pkg::event_kind_e kind,
                                                 input logic [5:0] tag,
                                                 input logic [7:0] text,
                                                 input wtp_pkg::status_e st,
                                                 input int depth);
    wtp_pkg::event_t e;
    e               = '0;
    e.kind          = kind;
    e.tag           = tag;
    e.text_byte     = text;
    e.status        = st;
    e.nesting_depth = depth[5:0];
    if (kind == wtp_pkg::EV_START) begin
      e.version            = hdr_version;
      e.public_id          = hdr_pubid;
      e.public_id_is_index = hdr_pubid_idx;
      e.charset            = hdr_charset;
    end
    return e;
  endfunction

  // returns 1 when the transfer produces an event
  function automatic bit step_parser_model(input logic op, input logic [7:0] b,
                                           output wtp_pkg::event_t ev);
    logic [31:0] v;
    ev = '0;
    if (op) begin
      if (!sticky_err && (ph != wtp_pkg::PH_BODY || open_cnt > 0))
        ev = make_event(wtp_pkg::EV_ERROR, '0, '0, wtp_pkg::ST_EARLY_END, 0);
      else
        ev = make_event(wtp_pkg::EV_END_DOC, '0, '0, wtp_pkg::ST_OK, 0);
      clear_parser_model();
      return 1'b1;
    end
    if (sticky_err) return 1'b0;
    case (ph)
      wtp_pkg::PH_VERSION: begin
        hdr_version = b;
        mb_acc      = '0;
        ph          = wtp_pkg::PH_PUBID;
        return 1'b0;
      end
      wtp_pkg::PH_PUBID, wtp_pkg::PH_PUBIDX, wtp_pkg::PH_CHARSET,
      wtp_pkg::PH_STRTBL_LEN, wtp_pkg::PH_OPQ_LEN: begin
        mb_acc = {mb_acc[24:0], b[6:0]};
        if (b[7]) return 1'b0;
        v      = mb_acc;
        mb_acc = '0;
        case (ph)
          wtp_pkg::PH_PUBID: begin
            if (v == 0) begin
              ph = wtp_pkg::PH_PUBIDX;
            end else begin
              hdr_pubid     = v;
              hdr_pubid_idx = 1'b0;
              ph            = wtp_pkg::PH_CHARSET;
            end
          end
          wtp_pkg::PH_PUBIDX: begin
            hdr_pubid     = v;
            hdr_pubid_idx = 1'b1;
            ph            = wtp_pkg::PH_CHARSET;
          end
          wtp_pkg::PH_CHARSET: begin
            hdr_charset = v;
            ph          = wtp_pkg::PH_STRTBL_LEN;
          end
          wtp_pkg::PH_STRTBL_LEN: begin
            if (v == 0) begin
              ph = wtp_pkg::PH_BODY;
              ev = make_event(wtp_pkg::EV_START, '0, '0, wtp_pkg::ST_OK, open_cnt);
              return 1'b1;
            end
            run_left = v;
            ph       = wtp_pkg::PH_STRTBL_SKIP;
          end
          default: begin
            if (v == 0) begin
              ph = wtp_pkg::PH_BODY;
            end else begin
              run_left = v;
              ph       = wtp_pkg::PH_OPQ_DATA;
            end
          end
        endcase
        return 1'b0;
      end
      wtp_pkg::PH_STRTBL_SKIP: begin
        run_left = run_left - 1;
        if (run_left != 0) return 1'b0;
        ph = wtp_pkg::PH_BODY;
        ev = make_event(wtp_pkg::EV_START, '0, '0, wtp_pkg::ST_OK, open_cnt);
        return 1'b1;
      end
      wtp_pkg::PH_STR: begin
        if (b == 8'h00) begin
          ph = wtp_pkg::PH_BODY;
          ev = make_event(wtp_pkg::EV_TEXT_END, '0, '0, wtp_pkg::ST_OK, open_cnt);
        end else begin
          ev = make_event(wtp_pkg::EV_TEXT, '0, b, wtp_pkg::ST_OK, open_cnt);
        end
        return 1'b1;
      end
      wtp_pkg::PH_OPQ_DATA: begin
        run_left = run_left - 1;
        if (run_left == 0) ph = wtp_pkg::PH_BODY;
        ev = make_event(wtp_pkg::EV_TEXT, '0, b, wtp_pkg::ST_OK, open_cnt);
        return 1'b1;
      end
      wtp_pkg::PH_BODY: begin
        if (b == wtp_pkg::TOK_END) begin
          if (open_cnt == 0) begin
            sticky_err = 1'b1;
            ev = make_event(wtp_pkg::EV_ERROR, '0, '0, wtp_pkg::ST_EMPTY_CLOSE, open_cnt);
            return 1'b1;
          end
          open_cnt--;
          ev = make_event(wtp_pkg::EV_CLOSE, tag_stk[open_cnt], '0, wtp_pkg::ST_OK,
                          open_cnt);
          return 1'b1;
        end
        if (b == wtp_pkg::TOK_STR_I) begin
          ph = wtp_pkg::PH_STR;
          return 1'b0;
        end
        if (b == wtp_pkg::TOK_OPAQUE) begin
          mb_acc = '0;
          ph     = wtp_pkg::PH_OPQ_LEN;
          return 1'b0;
        end
        if (b[6]) begin
          if (open_cnt >= wtp_pkg::STACK_DEPTH) begin
            sticky_err = 1'b1;
            ev = make_event(wtp_pkg::EV_ERROR, '0, '0, wtp_pkg::ST_OVERFLOW, open_cnt);
            return 1'b1;
          end
          tag_stk[open_cnt] = b[5:0];
          open_cnt++;
          ev = make_event(wtp_pkg::EV_OPEN, b[5:0], '0, wtp_pkg::ST_OK, open_cnt);
          return 1'b1;
        end
        ev = make_event(wtp_pkg::EV_EMPTY, b[5:0], '0, wtp_pkg::ST_OK, open_cnt);
        return 1'b1;
      end
      default: begin
        ph = wtp_pkg::PH_VERSION;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("event %0d %s got 0x%0h want 0x%0h", evt_cnt, name, got, want));
  endtask

  // output check and input prediction, both sampled at the clock edge
  always @(posedge clk_i) begin : scoreboard
    wtp_pkg::event_t want;
    wtp_pkg::event_t fresh;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          flag_error($sformatf("event %0d kind %0d with nothing expected",
                               evt_cnt, event_kind_o));
        end else begin
          want = pending_events.pop_front();
          cmp_field("kind", event_kind_o, want.kind);
          cmp_field("tag", tag_o, want.tag);
          cmp_field("text_byte", text_byte_o, want.text_byte);
          cmp_field("version", version_o, want.version);
          cmp_field("public_id", public_id_o, want.public_id);
          cmp_field("public_id_is_index", public_id_is_index_o, want.public_id_is_index);
          cmp_field("charset", charset_o, want.charset);
          cmp_field("status", status_o, want.status);
          cmp_field("nesting_depth", nesting_depth_o, want.nesting_depth);
        end
        evt_cnt++;
      end
      if (in_valid_i && !in_stall_o) begin
        if (step_parser_model(op_i, data_byte_i, fresh)) pending_events.push_back(fresh);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
          $display("wbxml_token_parser verification failed");
          $finish;
        end
      end
    end
  end

  // receiver: short random stall bursts, plus one long hold on request
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // call at a rising edge; returns at the edge of the transfer
  task automatic put_item(input logic op, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  task automatic put_mb(input logic [34:0] val, input int groups);
    for (int i = groups - 1; i >= 0; i--) put_item(1'b0, {i != 0, val[7*i +: 7]});
  endtask

  task automatic send_basic_header();
    put_item(1'b0, 8'h03);
    put_item(1'b0, 8'h01);
    put_item(1'b0, 8'h6A);
    put_item(1'b0, 8'h00);
  endtask

  function automatic logic [7:0] element_byte(input bit with_content);
    logic [7:0] b;
    do begin
      b    = 8'($urandom);
      b[6] = with_content;
    end while (b == wtp_pkg::TOK_END || b == wtp_pkg::TOK_STR_I ||
               b == wtp_pkg::TOK_OPAQUE);
    return b;
  endfunction

  task automatic test_header_forms();
    // end of document before any byte
    put_item(1'b1, 8'h00);
    // index form of the public id, wrapping values, skipped string table
    put_item(1'b0, 8'hFF);
    put_mb(35'h0, 1);
    put_mb(35'h7_FFFF_FFFF, 5);
    put_mb(35'h6A, 2);
    put_mb(35'h3, 1);
    put_item(1'b0, 8'h00);
    put_item(1'b0, 8'hFF);
    put_item(1'b0, 8'h01);
    put_item(1'b1, 8'hFF);
    // literal public id, early end inside the header
    put_item(1'b0, 8'h00);
    put_mb(35'h1, 1);
    put_item(1'b1, 8'h00);
  endtask

  task automatic test_element_tokens();
    send_basic_header();
    put_item(1'b0, 8'h40);
    put_item(1'b0, 8'hFF);
    put_item(1'b0, 8'h3F);
    put_item(1'b0, 8'h80);
    put_item(1'b0, 8'h00);
    put_item(1'b0, wtp_pkg::TOK_END);
    put_item(1'b0, wtp_pkg::TOK_END);
    put_item(1'b1, 8'h00);
  endtask

  task automatic test_inline_and_opaque();
    send_basic_header();
    put_item(1'b0, wtp_pkg::TOK_STR_I);
    put_item(1'b0, 8'h41);
    put_item(1'b0, 8'hFF);
    put_item(1'b0, 8'h00);
    put_item(1'b0, wtp_pkg::TOK_STR_I);
    put_item(1'b0, 8'h00);
    put_item(1'b0, wtp_pkg::TOK_OPAQUE);
    put_item(1'b0, 8'h00);
    put_item(1'b0, wtp_pkg::TOK_OPAQUE);
    put_mb(35'h2, 2);
    put_item(1'b0, 8'h00);
    put_item(1'b0, 8'hFF);
    put_item(1'b1, 8'h00);
  endtask

  task automatic test_error_paths();
    // close on empty stack, then sticky
    send_basic_header();
    put_item(1'b0, wtp_pkg::TOK_END);
    put_item(1'b0, 8'h40);
    put_item(1'b1, 8'h00);
    // end with open element, inside string, inside opaque
    send_basic_header();
    put_item(1'b0, 8'h45);
    put_item(1'b1, 8'h00);
    send_basic_header();
    put_item(1'b0, wtp_pkg::TOK_STR_I);
    put_item(1'b0, 8'h78);
    put_item(1'b1, 8'h00);
    send_basic_header();
    put_item(1'b0, wtp_pkg::TOK_OPAQUE);
    put_item(1'b0, 8'h05);
    put_item(1'b0, 8'h11);
    put_item(1'b1, 8'h00);
  endtask

  task automatic test_stack_overflow();
    send_basic_header();
    repeat (wtp_pkg::STACK_DEPTH + 1) put_item(1'b0, element_byte(1'b1));
    put_item(1'b0, wtp_pkg::TOK_END);
    put_item(1'b1, 8'h00);
  endtask

  task automatic test_full_backpressure();
    hold_req <= 1'b1;
    send_basic_header();
    put_item(1'b0, wtp_pkg::TOK_STR_I);
    repeat (40) put_item(1'b0, 8'($urandom_range(1, 255)));
    put_item(1'b0, 8'h00);
    put_item(1'b1, 8'h00);
  endtask

  task automatic send_random_doc();
    int         gen_depth;
    int         n_tok;
    int         len;
    int         pick;
    int         cap;
    bit         deep;
    gen_depth = 0;
    deep      = ($urandom_range(0, 11) == 0);
    cap       = deep ? wtp_pkg::STACK_DEPTH + 2 : 10;
    put_item(1'b0, 8'($urandom));
    if ($urandom_range(0, 4) == 0) put_mb(35'h0, $urandom_range(1, 2));
    put_mb(35'({$urandom, $urandom}), $urandom_range(1, 5));
    put_mb(35'({$urandom, $urandom}), $urandom_range(1, 5));
    len = $urandom_range(0, 4);
    put_mb(35'(len), $urandom_range(1, 2));
    repeat (len) put_item(1'b0, 8'($urandom));
    if (deep) begin
      repeat ($urandom_range(wtp_pkg::STACK_DEPTH - 2, wtp_pkg::STACK_DEPTH + 2)) begin
        put_item(1'b0, element_byte(1'b1));
        gen_depth++;
      end
    end
    n_tok = $urandom_range(0, 30);
    repeat (n_tok) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 && gen_depth < cap) begin
        put_item(1'b0, element_byte(1'b1));
        gen_depth++;
      end else if (pick < 50) begin
        put_item(1'b0, element_byte(1'b0));
      end else if (pick < 68) begin
        if (gen_depth > 0) gen_depth--;
        put_item(1'b0, wtp_pkg::TOK_END);
      end else if (pick < 82) begin
        put_item(1'b0, wtp_pkg::TOK_STR_I);
        repeat ($urandom_range(0, 6)) put_item(1'b0, 8'($urandom_range(1, 255)));
        put_item(1'b0, 8'h00);
      end else if (pick < 94) begin
        len = $urandom_range(0, 6);
        put_item(1'b0, wtp_pkg::TOK_OPAQUE);
        put_mb(35'(len), $urandom_range(1, 2));
        repeat (len) put_item(1'b0, 8'($urandom));
      end else if (pick < 98) begin
        put_item(1'b0, 8'($urandom));
      end else begin
        put_item(1'b1, 8'($urandom));
        return;
      end
    end
    while (gen_depth > 0 && $urandom_range(0, 9) != 0) begin
      put_item(1'b0, wtp_pkg::TOK_END);
      gen_depth--;
    end
    put_item(1'b1, 8'($urandom));
  endtask

  task automatic test_random_documents();
    while (sent_cnt < ITEM_TARGET) begin
      if (sent_cnt > ITEM_TARGET - 250) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 3) != 0);
      send_random_doc();
    end
  endtask

  initial begin
    clear_parser_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_forms();
    test_element_tokens();
    test_inline_and_opaque();
    test_error_paths();
    test_stack_overflow();
    test_full_backpressure();
    test_random_documents();

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (err_cnt == 0 && pending_events.size() == 0) begin
      $display("wbxml_token_parser verification clean");
    end else begin
      $display("wbxml_token_parser verification failed");
    end
    $finish;
  end

endmodule
